>>> src/tss_pkg.sv
// Shared types and constants for the thermal session sequencer.
`timescale 1ns / 1ps
package tss_pkg;

  localparam int unsigned MaxSessionsDef = 5;
  localparam int unsigned TargetW        = 12;
  localparam int unsigned LevelW         = 7;
  localparam int unsigned TempW          = 13;
  localparam int unsigned IdxW           = 3;
  localparam int unsigned CountW         = 32;
  localparam int unsigned TableSlots     = 5;
  localparam int unsigned TargetsW       = TargetW * TableSlots;
  localparam int unsigned LevelsW        = LevelW * TableSlots;
  localparam int unsigned CfgIdxW        = 2;

  localparam logic [LevelW-1:0] LevelMax = 7'd100;

  // 26, 29, 31, 33, 36 degC in 1/16 degC, session 0 highest
  localparam logic [TargetsW-1:0] TargetsRst = 60'h1A0_1D0_1F0_210_240;
  localparam logic [LevelsW-1:0]  LevelsRst  = {7'd40, 7'd40, 7'd60, 7'd40, 7'd40};
  localparam logic [TempW-1:0]    StopRst    = 13'd616;
  localparam logic [IdxW-1:0]     CountRst   = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGETS = 2'd0,
    CFG_LEVELS  = 2'd1,
    CFG_STOP    = 2'd2,
    CFG_COUNT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_LOG   = 3'd1,
    PH_COOL  = 3'd2,
    PH_READY = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    BZ_NONE   = 3'd0,
    BZ_STOP   = 3'd1,
    BZ_TRIPLE = 3'd2,
    BZ_FINISH = 3'd3,
    BZ_COOL   = 3'd4,
    BZ_READY  = 3'd5
  } buzzer_e;

  typedef struct packed {
    phase_e              phase;
    logic [IdxW-1:0]     session;
    logic [CountW-1:0]   count;
    logic                door_was_open;
    logic [LevelW-1:0]   heater;
  } tss_state_t;

  typedef struct packed {
    logic [TargetsW-1:0]    targets;
    logic [LevelsW-1:0]     levels;
    logic signed [TempW-1:0] stop_temp;
    logic [IdxW-1:0]        count;
  } tss_cfg_t;

  typedef struct packed {
    logic                    sensor_ok;
    logic signed [TempW-1:0] temperature;
    logic                    door_ajar;
  } tss_sample_t;

  typedef struct packed {
    logic [LevelW-1:0] heater_level;
    buzzer_e           buzzer_cmd;
    logic              record_valid;
    logic [LevelW-1:0] record_level;
    phase_e            phase;
    logic [IdxW-1:0]   session_index;
    logic [CountW-1:0] sample_count;
  } tss_result_t;

endpackage

>>> src/tss_step.sv
// Next-state and result logic for one temperature sample.
`timescale 1ns / 1ps
module tss_step import tss_pkg::*; #(
  parameter int unsigned MAX_SESSIONS = MaxSessionsDef
) (
  input  tss_state_t  state_i,
  input  tss_cfg_t    cfg_i,
  input  tss_sample_t sample_i,
  output tss_state_t  state_o,
  output tss_result_t result_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_SESSIONS - 1);
  localparam logic [IdxW-1:0] NumSess = IdxW'(MAX_SESSIONS);

  logic [IdxW-1:0]          cur_idx, nxt_raw, nxt_idx, in_use;
  logic [IdxW:0]            nxt_sum;
  logic signed [TempW-1:0]  cur_target, nxt_target;
  logic [LevelW-1:0]        lvl_raw, cur_level;
  logic [LevelW-1:0]        heat;
  buzzer_e                  buzzer;
  logic                     rec;
  logic [LevelW-1:0]        rec_level;
  tss_state_t               nxt;

  always_comb begin
    cur_idx = (state_i.session >= NumSess) ? LastIdx : state_i.session;
    nxt_sum = {1'b0, state_i.session} + {{IdxW{1'b0}}, 1'b1};
    nxt_raw = (nxt_sum >= {1'b0, NumSess}) ? LastIdx : nxt_sum[IdxW-1:0];
    nxt_idx = nxt_raw;
    in_use  = cfg_i.count;
    if (in_use == '0) begin
      in_use = IdxW'(1);
    end
    if (in_use > NumSess) begin
      in_use = NumSess;
    end
    cur_target = TempW'($signed(cfg_i.targets[cur_idx * TargetW +: TargetW]));
    nxt_target = TempW'($signed(cfg_i.targets[nxt_idx * TargetW +: TargetW]));
    lvl_raw    = cfg_i.levels[cur_idx * LevelW +: LevelW];
    cur_level  = (lvl_raw > LevelMax) ? LevelMax : lvl_raw;
  end

  always_comb begin
    nxt       = state_i;
    buzzer    = BZ_NONE;
    rec       = 1'b0;
    rec_level = '0;
    heat      = state_i.heater;
    if (sample_i.sensor_ok) begin
      if (sample_i.door_ajar) begin
        heat = '0;
      end
      unique case (state_i.phase)
        PH_WAIT: begin
          heat = '0;
          if (sample_i.temperature <= cur_target) begin
            nxt.phase = PH_LOG;
            nxt.count = '0;
            buzzer    = BZ_TRIPLE;
          end
        end
        PH_LOG: begin
          if (!sample_i.door_ajar) begin
            heat = cur_level;
          end
          nxt.count = state_i.count + CountW'(1);
          rec       = 1'b1;
          rec_level = sample_i.door_ajar ? '0 : cur_level;
          if (sample_i.temperature >= cfg_i.stop_temp) begin
            heat = '0;
            if (nxt_sum >= {1'b0, in_use}) begin
              nxt.phase = PH_DONE;
              buzzer    = BZ_FINISH;
            end else begin
              nxt.phase = PH_COOL;
              buzzer    = BZ_COOL;
            end
          end
        end
        PH_COOL: begin
          heat = '0;
          if (sample_i.temperature <= nxt_target) begin
            nxt.phase = PH_READY;
            buzzer    = BZ_READY;
          end
        end
        PH_READY: begin
          heat = '0;
          if (!sample_i.door_ajar && state_i.door_was_open) begin
            nxt.session = nxt_raw;
            nxt.count   = '0;
            nxt.phase   = PH_LOG;
            buzzer      = BZ_TRIPLE;
          end
        end
        default: begin
          heat = '0;
        end
      endcase
      nxt.heater        = heat;
      nxt.door_was_open = sample_i.door_ajar;
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.heater_level  = nxt.heater;
    result_o.buzzer_cmd    = buzzer;
    result_o.record_valid  = rec;
    result_o.record_level  = rec_level;
    result_o.phase         = nxt.phase;
    result_o.session_index = nxt.session;
    result_o.sample_count  = nxt.count;
  end

endmodule

>>> src/thermal_session_sequencer.sv
// Top level of the thermal session sequencer: handshakes, registers and result stage.
// One sample beat is taken every clock cycle while in_ready_o is high; each result is
// offered once its sample has passed the input register, the single compare-and-select
// step and the result register. Samples keep flowing while a result waits to be taken,
// and stall only when both the input register and the result register hold a beat and
// the result is not being taken in that cycle. Configuration writes take effect at once;
// the user must make them only while the block is idle; the block does not check it.
`timescale 1ns / 1ps
module thermal_session_sequencer import tss_pkg::*; #(
  parameter int unsigned MAX_SESSIONS = MaxSessionsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [TargetsW-1:0]      cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     sensor_ok_i,
  input  logic signed [TempW-1:0]  temperature_i,
  input  logic                     door_ajar_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [LevelW-1:0]        heater_level_o,
  output logic [2:0]               buzzer_cmd_o,
  output logic                     record_valid_o,
  output logic [LevelW-1:0]        record_level_o,
  output logic [2:0]               phase_o,
  output logic [IdxW-1:0]          session_index_o,
  output logic [CountW-1:0]        sample_count_o
);

  tss_cfg_t    cfg_q;
  tss_state_t  state_q, state_d;
  tss_sample_t smp_q;
  logic        smp_vld_q;
  tss_result_t res_q, res_d;
  logic        res_vld_q;
  logic        res_free, advance;

  assign res_free   = !res_vld_q || out_ready_i;
  assign advance    = smp_vld_q && res_free;
  assign in_ready_o = !smp_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.targets   <= TargetsRst;
      cfg_q.levels    <= LevelsRst;
      cfg_q.stop_temp <= StopRst;
      cfg_q.count     <= CountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGETS: cfg_q.targets   <= cfg_wdata_i;
        CFG_LEVELS:  cfg_q.levels    <= cfg_wdata_i[LevelsW-1:0];
        CFG_STOP:    cfg_q.stop_temp <= cfg_wdata_i[TempW-1:0];
        CFG_COUNT:   cfg_q.count     <= cfg_wdata_i[IdxW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q.sensor_ok   <= sensor_ok_i;
      smp_q.temperature <= temperature_i;
      smp_q.door_ajar   <= door_ajar_i;
    end
  end

  tss_step #(
    .MAX_SESSIONS(MAX_SESSIONS)
  ) u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .sample_i(smp_q),
    .state_o (state_d),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_WAIT;
      state_q.session       <= '0;
      state_q.count         <= '0;
      state_q.door_was_open <= 1'b0;
      state_q.heater        <= '0;
      res_vld_q             <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (res_free) begin
        res_vld_q <= smp_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign heater_level_o  = res_q.heater_level;
  assign buzzer_cmd_o    = res_q.buzzer_cmd;
  assign record_valid_o  = res_q.record_valid;
  assign record_level_o  = res_q.record_level;
  assign phase_o         = res_q.phase;
  assign session_index_o = res_q.session_index;
  assign sample_count_o  = res_q.sample_count;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the thermal session sequencer: directed table, then random.
`timescale 1ns / 1ps
module tb_top;
  import tss_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 64;
  localparam int BeatsPerStep  = 160;
  localparam int SettingSteps  = 8;
  localparam int TempLo        = -720;
  localparam int TempHi        = 2080;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic                    ok;
    logic signed [TempW-1:0] temp;
    logic                    door;
    logic                    typed;
    logic [LevelW-1:0]       heat;
    buzzer_e                 bz;
    logic                    rec;
    logic [LevelW-1:0]       rec_lvl;
    phase_e                  ph;
    logic [IdxW-1:0]         sess;
    logic [CountW-1:0]       cnt;
  } dir_row_t;

  // reset table: targets 576,528,496,464,416; levels 40,40,60,40,40; stop 616
  localparam dir_row_t DirectedRows [21] = '{
    '{1'b0, -13'sd720, 1'b0, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0},
    '{1'b1, 13'sd2080, 1'b1, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0},
    '{1'b1, 13'sd577,  1'b0, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0},
    '{1'b1, 13'sd576,  1'b0, 1'b1, 7'd0,  BZ_TRIPLE, 1'b0, 7'd0,  PH_LOG,   3'd0, 32'd0},
    '{1'b1, -13'sd720, 1'b0, 1'b1, 7'd40, BZ_NONE,   1'b1, 7'd40, PH_LOG,   3'd0, 32'd1},
    '{1'b1, 13'sd0,    1'b1, 1'b1, 7'd0,  BZ_NONE,   1'b1, 7'd0,  PH_LOG,   3'd0, 32'd2},
    '{1'b0, 13'sd2080, 1'b0, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_LOG,   3'd0, 32'd2},
    '{1'b1, 13'sd615,  1'b0, 1'b1, 7'd40, BZ_NONE,   1'b1, 7'd40, PH_LOG,   3'd0, 32'd3},
    '{1'b1, 13'sd616,  1'b0, 1'b1, 7'd0,  BZ_COOL,   1'b1, 7'd40, PH_COOL,  3'd0, 32'd4},
    '{1'b1, 13'sd600,  1'b0, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_COOL,  3'd0, 32'd4},
    '{1'b1, 13'sd528,  1'b1, 1'b1, 7'd0,  BZ_READY,  1'b0, 7'd0,  PH_READY, 3'd0, 32'd4},
    '{1'b1, 13'sd100,  1'b1, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_READY, 3'd0, 32'd4},
    '{1'b0, 13'sd0,    1'b0, 1'b1, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_READY, 3'd0, 32'd4},
    '{1'b1, 13'sd100,  1'b0, 1'b1, 7'd0,  BZ_TRIPLE, 1'b0, 7'd0,  PH_LOG,   3'd1, 32'd0},
    '{1'b1, 13'sd2080, 1'b0, 1'b1, 7'd0,  BZ_COOL,   1'b1, 7'd40, PH_COOL,  3'd1, 32'd1},
    '{1'b1, 13'sd495,  1'b0, 1'b1, 7'd0,  BZ_READY,  1'b0, 7'd0,  PH_READY, 3'd1, 32'd1},
    '{1'b1, -13'sd1,   1'b0, 1'b0, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0},
    '{1'b1, 13'sd1000, 1'b1, 1'b0, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0},
    '{1'b1, 13'sd0,    1'b0, 1'b1, 7'd0,  BZ_TRIPLE, 1'b0, 7'd0,  PH_LOG,   3'd2, 32'd0},
    '{1'b1, 13'sd10,   1'b0, 1'b1, 7'd60, BZ_NONE,   1'b1, 7'd60, PH_LOG,   3'd2, 32'd1},
    '{1'b1, -13'sd1,   1'b1, 1'b0, 7'd0,  BZ_NONE,   1'b0, 7'd0,  PH_WAIT,  3'd0, 32'd0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = CFG_TARGETS;
  logic [TargetsW-1:0]     cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    sensor_ok_i = 1'b0;
  logic signed [TempW-1:0] temperature_i = '0;
  logic                    door_ajar_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [LevelW-1:0]       heater_level_o;
  logic [2:0]              buzzer_cmd_o;
  logic                    record_valid_o;
  logic [LevelW-1:0]       record_level_o;
  logic [2:0]              phase_o;
  logic [IdxW-1:0]         session_index_o;
  logic [CountW-1:0]       sample_count_o;

  thermal_session_sequencer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sensor_ok_i     (sensor_ok_i),
    .temperature_i   (temperature_i),
    .door_ajar_i     (door_ajar_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .heater_level_o  (heater_level_o),
    .buzzer_cmd_o    (buzzer_cmd_o),
    .record_valid_o  (record_valid_o),
    .record_level_o  (record_level_o),
    .phase_o         (phase_o),
    .session_index_o (session_index_o),
    .sample_count_o  (sample_count_o)
  );

  always #5 clk_i = ~clk_i;

  // chamber model: register copies and sequencing state
  logic [TargetsW-1:0]     cfg_targets = TargetsRst;
  logic [LevelsW-1:0]      cfg_levels  = LevelsRst;
  logic signed [TempW-1:0] cfg_stop    = StopRst;
  logic [IdxW-1:0]         cfg_count   = CountRst;

  phase_e            chamber_phase   = PH_WAIT;
  logic [IdxW-1:0]   chamber_session = '0;
  logic [CountW-1:0] chamber_count   = '0;
  logic              door_was_open   = 1'b0;
  logic [LevelW-1:0] heater_now      = '0;

  tss_result_t chamber_reports_q [$];

  idle_mode_e idle_mode = IDLE_NONE;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_cycles = 0;
  int         mismatches = 0;
  int         reports_checked = 0;
  int         beats_sent = 0;
  int         failed_reads = 0;
  int         sessions_started = 0;
  int         runs_finished = 0;

  function automatic int target_for(input int idx);
    int i;
    logic [TargetW-1:0] raw;
    i = (idx >= int'(MaxSessionsDef)) ? int'(MaxSessionsDef) - 1 : idx;
    raw = cfg_targets[i*TargetW +: TargetW];
    return int'($signed(raw));
  endfunction

  function automatic logic [LevelW-1:0] level_for(input int idx);
    int i;
    logic [LevelW-1:0] v;
    i = (idx >= int'(MaxSessionsDef)) ? int'(MaxSessionsDef) - 1 : idx;
    v = cfg_levels[i*LevelW +: LevelW];
    return (v > LevelMax) ? LevelMax : v;
  endfunction

  function automatic int sessions_in_play();
    int n;
    n = int'(cfg_count);
    if (n < 1) n = 1;
    if (n > int'(MaxSessionsDef)) n = int'(MaxSessionsDef);
    return n;
  endfunction

  function automatic tss_result_t advance_chamber(input tss_sample_t s);
    tss_result_t r;
    int t;
    int nxt;
    logic [LevelW-1:0] heat;
    r = '0;
    r.buzzer_cmd = BZ_NONE;
    if (s.sensor_ok) begin
      t = int'($signed(s.temperature));
      heat = s.door_ajar ? '0 : heater_now;
      case (chamber_phase)
        PH_WAIT: begin
          heat = '0;
          if (t <= target_for(int'(chamber_session))) begin
            chamber_phase = PH_LOG;
            chamber_count = '0;
            r.buzzer_cmd = BZ_TRIPLE;
          end
        end
        PH_LOG: begin
          if (!s.door_ajar) heat = level_for(int'(chamber_session));
          chamber_count = chamber_count + 1;
          r.record_valid = 1'b1;
          r.record_level = s.door_ajar ? '0 : level_for(int'(chamber_session));
          if (t >= int'(cfg_stop)) begin
            heat = '0;
            if (int'(chamber_session) + 1 >= sessions_in_play()) begin
              chamber_phase = PH_DONE;
              r.buzzer_cmd = BZ_FINISH;
            end else begin
              chamber_phase = PH_COOL;
              r.buzzer_cmd = BZ_COOL;
            end
          end
        end
        PH_COOL: begin
          heat = '0;
          if (t <= target_for(int'(chamber_session) + 1)) begin
            chamber_phase = PH_READY;
            r.buzzer_cmd = BZ_READY;
          end
        end
        PH_READY: begin
          heat = '0;
          if (!s.door_ajar && door_was_open) begin
            nxt = int'(chamber_session) + 1;
            if (nxt >= int'(MaxSessionsDef)) nxt = int'(MaxSessionsDef) - 1;
            chamber_session = IdxW'(nxt);
            chamber_count = '0;
            chamber_phase = PH_LOG;
            r.buzzer_cmd = BZ_TRIPLE;
          end
        end
        default: begin
          heat = '0;
        end
      endcase
      heater_now = heat;
      door_was_open = s.door_ajar;
    end
    if (r.buzzer_cmd == BZ_TRIPLE) sessions_started++;
    if (r.buzzer_cmd == BZ_FINISH) runs_finished++;
    r.heater_level = heater_now;
    r.phase = chamber_phase;
    r.session_index = chamber_session;
    r.sample_count = chamber_count;
    return r;
  endfunction

  function automatic int clamp_temp(input int v);
    if (v < TempLo) return TempLo;
    if (v > TempHi) return TempHi;
    return v;
  endfunction

  // mostly samples that hold the current phase and now and then cross its threshold, some noise and failed reads
  function automatic tss_sample_t pick_sample();
    tss_sample_t s;
    int r;
    int t;
    r = int'($urandom_range(0, 99));
    s.sensor_ok = (r >= 7);
    s.door_ajar = ($urandom_range(0, 9) == 0);
    if (r < 15) begin
      t = int'($urandom_range(0, TempHi - TempLo)) + TempLo;
      s.door_ajar = ($urandom_range(0, 1) == 1);
    end else begin
      case (chamber_phase)
        PH_WAIT:
          t = ($urandom_range(0, 79) == 0)
              ? target_for(int'(chamber_session)) - int'($urandom_range(0, 80))
              : target_for(int'(chamber_session)) + 1 + int'($urandom_range(0, 300));
        PH_LOG:
          t = ($urandom_range(0, 49) == 0)
              ? int'(cfg_stop) + int'($urandom_range(0, 80))
              : int'(cfg_stop) - 1 - int'($urandom_range(0, 400));
        PH_COOL:
          t = ($urandom_range(0, 79) == 0)
              ? target_for(int'(chamber_session) + 1) - int'($urandom_range(0, 80))
              : target_for(int'(chamber_session) + 1) + 1 + int'($urandom_range(0, 300));
        default:
          t = int'($urandom_range(0, TempHi - TempLo)) + TempLo;
      endcase
    end
    s.temperature = TempW'(clamp_temp(t));
    return s;
  endfunction

  function automatic bit sender_rests();
    case (idle_mode)
      IDLE_SEND: return ($urandom_range(0, 99) < 53);
      IDLE_BOTH: return ($urandom_range(0, 99) < 15);
      default:   return 1'b0;
    endcase
  endfunction

  task automatic send_sample(input tss_sample_t s, input bit use_typed,
                             input tss_result_t typed_res);
    tss_result_t pred;
    @(negedge clk_i);
    while (sender_rests()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sensor_ok_i   <= s.sensor_ok;
    temperature_i <= s.temperature;
    door_ajar_i   <= s.door_ajar;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_chamber(s);
    chamber_reports_q.push_back(use_typed ? typed_res : pred);
    beats_sent++;
    if (!s.sensor_ok) failed_reads++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (chamber_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [TargetsW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGETS: cfg_targets = val;
      CFG_LEVELS:  cfg_levels = val[LevelsW-1:0];
      CFG_STOP:    cfg_stop = val[TempW-1:0];
      default:     cfg_count = val[IdxW-1:0];
    endcase
  endtask

  task automatic apply_setting(input int step);
    logic [TargetsW-1:0] tg;
    for (int i = 0; i < int'(TableSlots); i++)
      tg[i*TargetW +: TargetW] = TargetW'($urandom_range(300, 700));
    case (step)
      0: write_reg(CFG_COUNT, TargetsW'(3'd7));
      1: write_reg(CFG_LEVELS, TargetsW'({LevelsW{1'b1}}));
      2: begin
        write_reg(CFG_STOP, TargetsW'($unsigned(TempW'(TempHi))));
        write_reg(CFG_TARGETS, TargetsRst);
      end
      3: begin
        write_reg(CFG_TARGETS, {TableSlots{12'h7FF}});
        write_reg(CFG_STOP, TargetsW'(StopRst));
      end
      4: begin
        write_reg(CFG_TARGETS, tg);
        write_reg(CFG_LEVELS, '0);
        write_reg(CFG_STOP, TargetsW'($unsigned(TempW'(TempLo))));
      end
      5: begin
        write_reg(CFG_TARGETS, tg);
        write_reg(CFG_LEVELS, TargetsW'({$urandom, $urandom}));
        write_reg(CFG_STOP, TargetsW'($urandom_range(500, 900)));
        write_reg(CFG_COUNT, TargetsW'(3'd5));
      end
      6: begin
        write_reg(CFG_TARGETS, {TableSlots{12'h800}});
        write_reg(CFG_COUNT, TargetsW'(3'd1));
      end
      default: begin
        write_reg(CFG_TARGETS, TargetsRst);
        write_reg(CFG_LEVELS, TargetsW'(LevelsRst));
        write_reg(CFG_STOP, TargetsW'(StopRst));
        write_reg(CFG_COUNT, TargetsW'(3'd0));
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_ready_i <= ($urandom_range(0, 99) >= 53);
        IDLE_BOTH: out_ready_i <= ($urandom_range(0, 99) >= 15);
        default:   out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin : report_check
    tss_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (chamber_reports_q.size() == 0) begin
        $display("%0t: report beat with none expected, phase %0d session %0d", $time,
                 phase_o, session_index_o);
        mismatches++;
      end else begin
        want = chamber_reports_q.pop_front();
        reports_checked++;
        check_field("heater_level", want.heater_level, heater_level_o);
        check_field("buzzer_cmd", want.buzzer_cmd, buzzer_cmd_o);
        check_field("record_valid", want.record_valid, record_valid_o);
        check_field("record_level", want.record_level, record_level_o);
        check_field("phase", want.phase, phase_o);
        check_field("session_index", want.session_index, session_index_o);
        check_field("sample_count", want.sample_count, sample_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no beat for %0d cycles", $time, WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    tss_sample_t s;
    tss_result_t typed_res;
    dir_row_t    row;
    int          good;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < $size(DirectedRows); i++) begin
      row = DirectedRows[i];
      s.sensor_ok   = row.ok;
      s.temperature = row.temp;
      s.door_ajar   = row.door;
      typed_res.heater_level  = row.heat;
      typed_res.buzzer_cmd    = row.bz;
      typed_res.record_valid  = row.rec;
      typed_res.record_level  = row.rec_lvl;
      typed_res.phase         = row.ph;
      typed_res.session_index = row.sess;
      typed_res.sample_count  = row.cnt;
      send_sample(s, row.typed, typed_res);
    end

    for (int step = 0; step < SettingSteps; step++) begin
      drain();
      apply_setting(step);
      idle_mode = idle_mode_e'(step % 4);
      if (step == 4) hold_req = 1'b1;
      good = 0;
      while (good < BeatsPerStep) begin
        s = pick_sample();
        send_sample(s, 1'b0, '0);
        if (s.sensor_ok) good++;
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (chamber_reports_q.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, chamber_reports_q.size());
      mismatches++;
    end
    $display("Sent %0d sample beats (%0d failed reads) across %0d register settings.",
             beats_sent, failed_reads, SettingSteps + 1);
    $display("Checked %0d reports: %0d sessions started, %0d runs finished, %0d mismatches.",
             reports_checked, sessions_started, runs_finished, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/tss_pkg.sv
src/tss_step.sv
src/thermal_session_sequencer.sv
dv/tb_top.sv
